// ----- src/tcpu_pkg.sv -----
// Shared constants and types for the toy CPU execute unit.
package tcpu_pkg;

  localparam logic [31:0] PROGRAM_START_DEF   = 32'h0000_0000;
  localparam int          STORE_ADDR_BITS_DEF = 12;

  localparam int WORD_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int BYTE_LANES = WORD_W / BYTE_W;
  localparam int REG_COUNT  = 8;

  // Opcodes in instruction bits [31:24]; any other code executes as a no-op.
  localparam logic [7:0] OP_NOP = 8'h00;
  localparam logic [7:0] OP_MOV = 8'h01;
  localparam logic [7:0] OP_ADD = 8'h02;
  localparam logic [7:0] OP_SUB = 8'h03;
  localparam logic [7:0] OP_LD  = 8'h04;
  localparam logic [7:0] OP_ST  = 8'h05;
  localparam logic [7:0] OP_JMP = 8'h06;
  localparam logic [7:0] OP_JZ  = 8'h07;
  localparam logic [7:0] OP_JNZ = 8'h08;
  localparam logic [7:0] OP_HLT = 8'hFF;

  // Request controls from the execute stage to the data store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

endpackage

// ----- src/toy_cpu_execute_unit_top.sv -----
// Top level of the toy CPU execute unit: decode, execute, register file and result stage.
//
// Each request on the slave stream is one 32-bit instruction word (opcode [31:24],
// rd [23:21], rs [20:18], immediate select [17], signed imm16 [15:0]); each produces
// exactly one result on the master stream, in order. The unit runs as a short pipeline:
// the register file is read when the request is taken, the instruction executes in the
// next cycle (ALU, branch target, effective address, data store access), and the result
// sits in the output stage, where load data from the data store is merged. One
// instruction is taken per cycle, back to back; a later instruction that uses a register
// or flag written by an earlier one gets the value forwarded, including load data, with
// no bubble. Throughput is one per cycle and drops only while the master side stalls.
// After reset the data store is swept to zero one 32-bit row per cycle, 2**(STORE_ADDR_BITS-2)
// rows (1024 at the default), and tready stays low until the sweep is done. Loads and stores
// are little-endian words at any byte address; the address wraps inside the store. Once HALT
// has executed, every following instruction is reported as ignored until reset.
module toy_cpu_execute_unit_top #(
  parameter logic [31:0] PROGRAM_START   = tcpu_pkg::PROGRAM_START_DEF,
  parameter int          STORE_ADDR_BITS = tcpu_pkg::STORE_ADDR_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] instruction
  input  logic [31:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] ignored, [1] halted, [33:2] next_pc, [34] zero_flag, [35] negative_flag,
  // [36] reg_written, [39:37] reg_index, [71:40] reg_value, [72] mem_written,
  // [104:73] mem_address, [136:105] mem_value, [143:137] zero fill
  output logic [143:0] m_axis_tdata
);

  localparam int WORD_W   = tcpu_pkg::WORD_W;
  localparam int REG_CNT  = tcpu_pkg::REG_COUNT;
  localparam int IDX_W    = 3;

  // Handshake and pipeline advance
  logic adv;
  logic accept;
  logic store_busy;

  // Architectural state
  logic [WORD_W-1:0] regs [REG_CNT];
  logic [WORD_W-1:0] pc;
  logic              zero_mark;
  logic              negative_mark;
  logic              halt_mark;

  // Execute stage: instruction plus register operands read at request time
  logic              e_valid;
  logic [31:0]       e_instr;
  logic [WORD_W-1:0] e_rd_val;
  logic [WORD_W-1:0] e_rs_val;

  logic [7:0]        e_op;
  logic [IDX_W-1:0]  e_rd;
  logic [IDX_W-1:0]  e_rs;
  logic              e_imm_sel;
  logic [WORD_W-1:0] e_simm;

  // Result stage
  logic              w_valid;
  logic              w_ignored;
  logic              w_halted;
  logic [WORD_W-1:0] w_pc;
  logic              w_z;
  logic              w_n;
  logic              w_reg_written;
  logic              w_load;
  logic [IDX_W-1:0]  w_reg_index;
  logic [WORD_W-1:0] w_reg_value;
  logic              w_mem_written;
  logic [WORD_W-1:0] w_mem_address;
  logic [WORD_W-1:0] w_mem_value;
  logic [WORD_W-1:0] w_val;
  logic [WORD_W-1:0] load_word;

  // Execute results headed for the result stage
  logic              x_ignored;
  logic              x_halted;
  logic [WORD_W-1:0] x_pc;
  logic              x_reg_written;
  logic              x_load;
  logic [IDX_W-1:0]  x_reg_index;
  logic [WORD_W-1:0] x_reg_value;
  logic              x_mem_written;
  logic [WORD_W-1:0] x_mem_address;
  logic [WORD_W-1:0] x_mem_value;

  logic [WORD_W-1:0] rd_op;
  logic [WORD_W-1:0] rs_op;
  logic              z_cur;
  logic              n_cur;
  logic [WORD_W-1:0] pc_inc;
  logic [WORD_W-1:0] target;
  logic [WORD_W-1:0] operand;
  logic [WORD_W-1:0] ea_base;
  logic [WORD_W-1:0] ea;

  // Operand capture at request time
  logic [IDX_W-1:0]  in_rd;
  logic [IDX_W-1:0]  in_rs;
  logic              e_wr_fwd;
  logic [WORD_W-1:0] cap_rd;
  logic [WORD_W-1:0] cap_rs;

  logic              out_zero;
  logic              out_neg;
  logic [WORD_W-1:0] out_mem_value;

  tcpu_pkg::store_ctl_t store_ctl;

  // Advance whenever the result stage is empty or being taken.
  assign adv           = !w_valid || m_axis_tready;
  assign s_axis_tready = adv && !store_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign e_op      = e_instr[31:24];
  assign e_rd      = e_instr[23:21];
  assign e_rs      = e_instr[20:18];
  assign e_imm_sel = e_instr[17];
  assign e_simm    = {{16{e_instr[15]}}, e_instr[15:0]};

  // Result-stage value, with load data merged from the store.
  assign w_val = w_load ? load_word : w_reg_value;

  // Forward the result stage's register write and flags into execute.
  always_comb begin
    rd_op = (w_valid && w_reg_written && w_reg_index == e_rd) ? w_val : e_rd_val;
    rs_op = (w_valid && w_reg_written && w_reg_index == e_rs) ? w_val : e_rs_val;
    z_cur = (w_valid && w_reg_written) ? (w_val == '0) : zero_mark;
    n_cur = (w_valid && w_reg_written) ? w_val[WORD_W-1] : negative_mark;
  end

  assign pc_inc  = pc + WORD_W'(4);
  assign target  = pc_inc + {e_simm[WORD_W-3:0], 2'b00};
  assign operand = e_imm_sel ? e_simm : rs_op;
  assign ea_base = (e_op == tcpu_pkg::OP_ST) ? rd_op : rs_op;
  assign ea      = ea_base + e_simm;

  // Execute: decode and compute everything but load data.
  always_comb begin
    x_ignored     = halt_mark;
    x_halted      = halt_mark;
    x_pc          = pc;
    x_reg_written = 1'b0;
    x_load        = 1'b0;
    x_reg_index   = '0;
    x_reg_value   = '0;
    x_mem_written = 1'b0;
    x_mem_address = '0;
    x_mem_value   = '0;
    if (!halt_mark) begin
      x_pc = pc_inc;
      unique case (e_op)
        tcpu_pkg::OP_NOP: begin
        end
        tcpu_pkg::OP_MOV: begin
          x_reg_written = 1'b1;
          x_reg_index   = e_rd;
          x_reg_value   = operand;
        end
        tcpu_pkg::OP_ADD: begin
          x_reg_written = 1'b1;
          x_reg_index   = e_rd;
          x_reg_value   = rd_op + operand;
        end
        tcpu_pkg::OP_SUB: begin
          x_reg_written = 1'b1;
          x_reg_index   = e_rd;
          x_reg_value   = rd_op - operand;
        end
        tcpu_pkg::OP_LD: begin
          x_reg_written = 1'b1;
          x_load        = 1'b1;
          x_reg_index   = e_rd;
          x_mem_address = ea;
        end
        tcpu_pkg::OP_ST: begin
          x_mem_written = 1'b1;
          x_mem_address = ea;
          x_mem_value   = rs_op;
        end
        tcpu_pkg::OP_JMP: begin
          x_pc = target;
        end
        tcpu_pkg::OP_JZ: begin
          x_pc = z_cur ? target : pc_inc;
        end
        tcpu_pkg::OP_JNZ: begin
          x_pc = z_cur ? pc_inc : target;
        end
        tcpu_pkg::OP_HLT: begin
          x_pc     = pc;
          x_halted = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Register operands for an incoming request: the executing instruction's result
  // wins over the one committing from the result stage, which wins over the file.
  // A load in execute is not known yet; the result stage forwards it next cycle.
  assign in_rd    = s_axis_tdata[23:21];
  assign in_rs    = s_axis_tdata[20:18];
  assign e_wr_fwd = e_valid && x_reg_written && !x_load;

  always_comb begin
    if (e_wr_fwd && x_reg_index == in_rd) begin
      cap_rd = x_reg_value;
    end else if (w_valid && w_reg_written && w_reg_index == in_rd) begin
      cap_rd = w_val;
    end else begin
      cap_rd = regs[in_rd];
    end
    if (e_wr_fwd && x_reg_index == in_rs) begin
      cap_rs = x_reg_value;
    end else if (w_valid && w_reg_written && w_reg_index == in_rs) begin
      cap_rs = w_val;
    end else begin
      cap_rs = regs[in_rs];
    end
  end

  // Data store requests go out only when execute advances.
  always_comb begin
    store_ctl.rd_en = adv && e_valid && x_load;
    store_ctl.wr_en = adv && e_valid && x_mem_written;
  end

  tcpu_store #(
    .ADDR_BITS (STORE_ADDR_BITS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (store_ctl),
    .addr  (ea[STORE_ADDR_BITS-1:0]),
    .wdata (rs_op),
    .rdata (load_word),
    .busy  (store_busy)
  );

  // Control state: valids, PC, halt mark and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid       <= 1'b0;
      w_valid       <= 1'b0;
      pc            <= PROGRAM_START;
      halt_mark     <= 1'b0;
      zero_mark     <= 1'b0;
      negative_mark <= 1'b0;
    end else if (adv) begin
      e_valid <= accept;
      w_valid <= e_valid;
      if (e_valid) begin
        pc        <= x_pc;
        halt_mark <= x_halted;
      end
      // Flags commit as the writing instruction leaves the result stage.
      if (w_valid && w_reg_written) begin
        zero_mark     <= (w_val == '0);
        negative_mark <= w_val[WORD_W-1];
      end
    end
  end

  // Register file: one write port, committed from the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_CNT; i++) begin
        regs[i] <= '0;
      end
    end else if (adv && w_valid && w_reg_written) begin
      regs[w_reg_index] <= w_val;
    end
  end

  // Payload of the execute and result stages.
  always_ff @(posedge clk) begin
    if (accept) begin
      e_instr  <= s_axis_tdata;
      e_rd_val <= cap_rd;
      e_rs_val <= cap_rs;
    end
    if (adv) begin
      w_ignored     <= x_ignored;
      w_halted      <= x_halted;
      w_pc          <= x_pc;
      w_z           <= z_cur;
      w_n           <= n_cur;
      w_reg_written <= x_reg_written;
      w_load        <= x_load;
      w_reg_index   <= x_reg_index;
      w_reg_value   <= x_reg_value;
      w_mem_written <= x_mem_written;
      w_mem_address <= x_mem_address;
      w_mem_value   <= x_mem_value;
    end
  end

  // Result: writers report flags from the value written, others the flags they saw.
  assign out_zero      = w_reg_written ? (w_val == '0) : w_z;
  assign out_neg       = w_reg_written ? w_val[WORD_W-1] : w_n;
  assign out_mem_value = w_load ? load_word : w_mem_value;

  assign m_axis_tvalid = w_valid;
  assign m_axis_tdata  = {7'b0, out_mem_value, w_mem_address, w_mem_written, w_val,
                          w_reg_index, w_reg_written, out_neg, out_zero, w_pc,
                          w_halted, w_ignored};

  // Once halted, stay halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_mark |=> halt_mark)
    else $error("halt mark cleared without reset");

  // An ignored instruction changes nothing.
  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && w_ignored |-> w_halted && !w_reg_written && !w_mem_written)
    else $error("ignored instruction reports a write");

  // Flags committed by a writer match what its result reported.
  a_flag_commit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && w_reg_written |=>
      zero_mark == $past(out_zero) && negative_mark == $past(out_neg))
    else $error("committed flags differ from reported flags");

  // Nothing is in flight while the store is being cleared.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> !e_valid && !w_valid)
    else $error("instruction in flight during store clear");

endmodule

// ----- src/tcpu_store.sv -----
// Byte-addressed data store in four byte-lane banks with a clearing pass after reset.
module tcpu_store #(
  parameter int ADDR_BITS = tcpu_pkg::STORE_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tcpu_pkg::store_ctl_t        ctl,
  input  logic [ADDR_BITS-1:0]        addr,
  input  logic [tcpu_pkg::WORD_W-1:0] wdata,
  output logic [tcpu_pkg::WORD_W-1:0] rdata,
  output logic                        busy
);

  localparam int LANES     = tcpu_pkg::BYTE_LANES;
  localparam int BYTE_W    = tcpu_pkg::BYTE_W;
  localparam int LANE_BITS = $clog2(LANES);
  localparam int ROW_BITS  = ADDR_BITS - LANE_BITS;
  localparam int ROWS      = 1 << ROW_BITS;

  logic [ROW_BITS-1:0]  row;
  logic [LANE_BITS-1:0] lo;
  logic [ROW_BITS-1:0]  clr_row;
  logic [LANE_BITS-1:0] rd_lo;
  logic [BYTE_W-1:0]    lane_q [LANES];

  assign row = addr[ADDR_BITS-1:LANE_BITS];
  assign lo  = addr[LANE_BITS-1:0];

  // Sweep every row once after reset, writing zero into all lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + ROW_BITS'(1);
      if (&clr_row) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_lo <= lo;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [BYTE_W-1:0]    mem [ROWS];
    logic [ROW_BITS-1:0]  lane_row;
    logic [LANE_BITS-1:0] pos;
    logic [BYTE_W-1:0]    lane_wdata;

    // Lanes below the starting byte belong to the following row (wraps).
    assign lane_row   = (LANE_BITS'(l) < lo) ? row + ROW_BITS'(1) : row;
    assign pos        = LANE_BITS'(l) - lo;
    assign lane_wdata = wdata[pos*BYTE_W +: BYTE_W];

    always_ff @(posedge clk) begin
      if (busy) begin
        mem[clr_row] <= '0;
      end else if (ctl.wr_en) begin
        mem[lane_row] <= lane_wdata;
      end
      if (ctl.rd_en) begin
        lane_q[l] <= mem[lane_row];
      end
    end
  end

  // Rotate the lanes back into little-endian word order.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rdata[i*BYTE_W +: BYTE_W] = lane_q[LANE_BITS'(rd_lo + LANE_BITS'(i))];
    end
  end

endmodule
